// ===== hdl/gws_pkg.sv =====
// Shared types, constants and codes of the grid water spillage block.
package gws_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 256;
  localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;
  localparam int CELL_W      = $clog2(CELL_COUNT);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int SIZE_W      = 9;
  localparam int CNT_W       = CELL_W + 1;

  localparam logic [31:0] WATER_MAX     = 32'h7FFF_FFFF;
  localparam logic [61:0] LOSS_MAX      = 62'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [35:0] RATIO_INVERSE = 36'd100000000;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_MINUTE = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] CFG_ROWS      = 2'd0;
  localparam logic [1:0] CFG_COLUMNS   = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;
  localparam logic [6:0] MUL_STEPS = 7'd36;
  localparam logic [6:0] DIV_STEPS = 7'd64;

  typedef struct packed {
    logic        start;
    logic        op;
    logic [63:0] a;
    logic [35:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [CNT_W-1:0]  cells;
  } grid_cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CELL_W-1:0] cell_index;
    logic [30:0]       ground_height;
    logic [29:0]       water_amount;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] cell_water;
    logic [29:0] max_half_spill;
    logic [61:0] total_loss;
  } res_t;

endpackage

// ===== hdl/gws_alu.sv =====
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module gws_alu (
  input  logic              clk,
  input  logic              rst,
  input  gws_pkg::alu_req_t req,
  output gws_pkg::alu_rsp_t rsp
);
  import gws_pkg::*;

  logic        busy;
  logic        done;
  logic        op;
  logic [6:0]  cnt;
  logic [63:0] acc;
  logic [63:0] x;
  logic [35:0] y;
  logic [35:0] rem;
  logic [63:0] acc_next;
  logic [63:0] x_next;
  logic [35:0] y_next;
  logic [35:0] rem_next;
  logic [36:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh   = {rem, x[63]};
    fits     = rem_sh >= {1'b0, y};
    x_next   = {x[62:0], 1'b0};
    y_next   = y;
    rem_next = rem;
    if (op == ALU_MUL) begin
      acc_next = y[0] ? acc + x : acc;
      y_next   = {1'b0, y[35:1]};
    end else begin
      acc_next = {acc[62:0], fits};
      rem_next = fits ? 36'(rem_sh - {1'b0, y}) : rem_sh[35:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == ALU_MUL) ? MUL_STEPS : DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      x   <= req.a;
      y   <= req.b;
      acc <= '0;
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      x   <= x_next;
      y   <= y_next;
      rem <= rem_next;
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = acc;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("alu done while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("alu restarted while busy");
  a_cnt_run: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 7'd0) else $error("alu busy with zero count");

endmodule

// ===== hdl/gws_seq.sv =====
// Cell stores and the sequencer that runs writes, adds, reads and spillage minutes.
module gws_seq (
  input  logic               clk,
  input  logic               rst,
  input  gws_pkg::grid_cfg_t cfg,
  input  logic               start,
  input  gws_pkg::cmd_t      cmd,
  output logic               ready,
  output gws_pkg::res_t      res,
  input  logic               res_take
);
  import gws_pkg::*;

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_OPWT  = 5'd2;
  localparam logic [4:0] ST_OPGET = 5'd3;
  localparam logic [4:0] ST_DONE  = 5'd4;
  localparam logic [4:0] ST_CRD   = 5'd5;
  localparam logic [4:0] ST_CWT   = 5'd6;
  localparam logic [4:0] ST_CGET  = 5'd7;
  localparam logic [4:0] ST_NRD   = 5'd8;
  localparam logic [4:0] ST_NWT   = 5'd9;
  localparam logic [4:0] ST_NGET  = 5'd10;
  localparam logic [4:0] ST_NEVAL = 5'd11;
  localparam logic [4:0] ST_CHK   = 5'd12;
  localparam logic [4:0] ST_CHKWT = 5'd13;
  localparam logic [4:0] ST_SPWR  = 5'd14;
  localparam logic [4:0] ST_SHR   = 5'd15;
  localparam logic [4:0] ST_SHMWT = 5'd16;
  localparam logic [4:0] ST_SHDWT = 5'd17;
  localparam logic [4:0] ST_SHWR  = 5'd18;
  localparam logic [4:0] ST_SHN   = 5'd19;
  localparam logic [4:0] ST_NXC   = 5'd20;
  localparam logic [4:0] ST_QRD   = 5'd21;
  localparam logic [4:0] ST_QWT   = 5'd22;
  localparam logic [4:0] ST_QGET  = 5'd23;

  logic [4:0]        state;
  logic [CELL_W-1:0] maddr;
  cmd_t              cmd_r;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [CELL_W-1:0] i;
  logic [1:0]        d;
  logic [33:0]       cur;
  logic [33:0]       nh;
  logic [31:0]       own_g;
  logic [31:0]       w_cur;
  logic [34:0]       sum;
  logic [32:0]       top;
  logic [32:0]       diff_r [4];
  logic [3:0]        ge_r;
  logic [30:0]       spill_r;
  logic [30:0]       share_r;
  logic [29:0]       best;
  logic [29:0]       last_max;
  logic [61:0]       loss;
  logic [31:0]       rd_val;

  // stores
  logic [31:0] ground_mem [CELL_COUNT];
  logic [31:0] water_mem  [CELL_COUNT];
  logic [29:0] spill_mem  [CELL_COUNT];
  logic [31:0] inflow_mem [CELL_COUNT];
  logic [31:0] g_rd, w_rd, in_rd;
  logic [29:0] sh_rd;
  logic        g_we, w_we, sh_we, in_we;
  logic [31:0] g_wd, w_wd, in_wd;
  logic [29:0] sh_wd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  gws_alu u_alu (.clk(clk), .rst(rst), .req(alu_req), .rsp(alu_rsp));

  always_ff @(posedge clk) begin
    if (g_we) ground_mem[maddr] <= g_wd;
    g_rd <= ground_mem[maddr];
  end
  always_ff @(posedge clk) begin
    if (w_we) water_mem[maddr] <= w_wd;
    w_rd <= water_mem[maddr];
  end
  always_ff @(posedge clk) begin
    if (sh_we) spill_mem[maddr] <= sh_wd;
    sh_rd <= spill_mem[maddr];
  end
  always_ff @(posedge clk) begin
    if (in_we) inflow_mem[maddr] <= in_wd;
    in_rd <= inflow_mem[maddr];
  end

  // neighbour of the current cell in direction d: up, down, left, right
  logic              n_in;
  logic [CELL_W-1:0] n_idx;
  logic [CNT_W-1:0]  i_ext;
  always_comb begin
    i_ext = {1'b0, i};
    case (d)
      2'd0: begin
        n_in  = r != '0;
        n_idx = CELL_W'(i_ext - CNT_W'(cfg.cols));
      end
      2'd1: begin
        n_in  = ({1'b0, r} + 9'd1) < cfg.rows;
        n_idx = CELL_W'(i_ext + CNT_W'(cfg.cols));
      end
      2'd2: begin
        n_in  = c != '0;
        n_idx = CELL_W'(i_ext - 1'b1);
      end
      default: begin
        n_in  = ({1'b0, c} + 9'd1) < cfg.cols;
        n_idx = CELL_W'(i_ext + 1'b1);
      end
    endcase
  end

  logic        idx_ok;
  logic [32:0] add_sum;
  logic [31:0] add_sat;
  logic [33:0] cell_surf;
  logic        ge_now;
  logic [33:0] diff_now;
  logic [30:0] spill_c;
  logic        last_col, last_row, last_cell;
  logic [34:0] q_sum;
  logic [31:0] q_sat;
  logic [29:0] best_c;
  logic [62:0] loss_sum;
  logic [61:0] loss_sat;

  always_comb begin
    idx_ok    = {1'b0, cmd_r.cell_index} < cfg.cells;
    add_sum   = {w_rd[31], w_rd} + {3'b0, cmd_r.water_amount};
    add_sat   = ($signed(add_sum) > $signed({1'b0, WATER_MAX})) ? WATER_MAX : add_sum[31:0];
    cell_surf = {{2{g_rd[31]}}, g_rd} + {{2{w_rd[31]}}, w_rd};
    ge_now    = $signed(cur) >= $signed(nh);
    diff_now  = cur - nh;
    spill_c   = ({1'b0, w_cur} > {1'b0, top}) ? top[30:0] : w_cur[30:0];
    last_col  = ({1'b0, c} + 9'd1) == cfg.cols;
    last_row  = ({1'b0, r} + 9'd1) == cfg.rows;
    last_cell = ({1'b0, i} + 1'b1) == cfg.cells;
    q_sum     = {3'b0, w_rd} - {5'b0, sh_rd} + {3'b0, in_rd};
    q_sat     = ($signed(q_sum) > $signed({3'b0, WATER_MAX})) ? WATER_MAX : q_sum[31:0];
    best_c    = (sh_rd > best) ? sh_rd : best;
    loss_sum  = {1'b0, loss} + {33'b0, alu_rsp.result[30:1]};
    loss_sat  = (loss_sum > {1'b0, LOSS_MAX}) ? LOSS_MAX : loss_sum[61:0];
  end

  always_comb begin
    g_we  = 1'b0;
    w_we  = 1'b0;
    sh_we = 1'b0;
    in_we = 1'b0;
    g_wd  = {cmd_r.ground_height[30], cmd_r.ground_height};
    w_wd  = {2'b0, cmd_r.water_amount};
    sh_wd = spill_r[30:1];
    in_wd = in_rd + {2'b0, share_r[30:1]};
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_req.a     = {33'b0, spill_r};
    alu_req.b     = {3'b0, diff_r[d]};
    case (state)
      ST_CLR: begin
        sh_we = 1'b1;
        in_we = 1'b1;
        sh_wd = '0;
        in_wd = '0;
      end
      ST_OPGET: begin
        if (idx_ok && cmd_r.mode == MODE_WRITE) begin
          g_we = 1'b1;
          w_we = 1'b1;
        end
        if (idx_ok && cmd_r.mode == MODE_ADD) begin
          w_we = 1'b1;
          w_wd = add_sat;
        end
      end
      ST_CHK: begin
        alu_req.start = sum != '0;
        alu_req.a     = {33'b0, spill_c};
        alu_req.b     = RATIO_INVERSE;
      end
      ST_SPWR: sh_we = 1'b1;
      ST_SHR: alu_req.start = ge_r[d];
      ST_SHMWT: begin
        alu_req.start = alu_rsp.done;
        alu_req.op    = ALU_DIV;
        alu_req.a     = alu_rsp.result;
        alu_req.b     = {1'b0, sum};
      end
      ST_SHWR: in_we = 1'b1;
      ST_QGET: begin
        w_we  = 1'b1;
        w_wd  = q_sat;
        sh_we = 1'b1;
        in_we = 1'b1;
        sh_wd = '0;
        in_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      maddr    <= '0;
      loss     <= '0;
      last_max <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          maddr <= maddr + 1'b1;
          if (maddr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            cmd_r  <= cmd;
            maddr  <= cmd.cell_index;
            rd_val <= '0;
            r      <= '0;
            c      <= '0;
            i      <= '0;
            best   <= '0;
            state  <= (cmd.mode == MODE_MINUTE) ? ST_CRD : ST_OPWT;
          end
        end
        ST_OPWT: state <= ST_OPGET;
        ST_OPGET: begin
          if (idx_ok && cmd_r.mode == MODE_READ) rd_val <= w_rd;
          state <= ST_DONE;
        end
        ST_DONE: if (res_take) state <= ST_IDLE;
        ST_CRD: begin
          maddr <= i;
          state <= ST_CWT;
        end
        ST_CWT: state <= ST_CGET;
        ST_CGET: begin
          if ($signed(w_rd) <= 0) begin
            state <= ST_NXC;
          end else begin
            cur   <= cell_surf;
            own_g <= g_rd;
            w_cur <= w_rd;
            d     <= '0;
            sum   <= '0;
            top   <= '0;
            state <= ST_NRD;
          end
        end
        ST_NRD: begin
          if (n_in) begin
            maddr <= n_idx;
            state <= ST_NWT;
          end else begin
            nh    <= {{2{own_g[31]}}, own_g};
            state <= ST_NEVAL;
          end
        end
        ST_NWT: state <= ST_NGET;
        ST_NGET: begin
          nh    <= cell_surf;
          state <= ST_NEVAL;
        end
        ST_NEVAL: begin
          ge_r[d]   <= ge_now;
          diff_r[d] <= diff_now[32:0];
          if (ge_now) begin
            sum <= sum + {2'b0, diff_now[32:0]};
            if (diff_now[32:0] > top) top <= diff_now[32:0];
          end
          d     <= d + 2'd1;
          state <= (d == 2'd3) ? ST_CHK : ST_NRD;
        end
        ST_CHK: begin
          spill_r <= spill_c;
          state   <= (sum == '0) ? ST_NXC : ST_CHKWT;
        end
        ST_CHKWT: begin
          if (alu_rsp.done) begin
            if (alu_rsp.result > {29'b0, sum}) begin
              maddr <= i;
              state <= ST_SPWR;
            end else begin
              state <= ST_NXC;
            end
          end
        end
        ST_SPWR: begin
          d     <= '0;
          state <= ST_SHR;
        end
        ST_SHR: begin
          maddr <= n_idx;
          state <= ge_r[d] ? ST_SHMWT : ST_SHN;
        end
        ST_SHMWT: if (alu_rsp.done) state <= ST_SHDWT;
        ST_SHDWT: begin
          if (alu_rsp.done) begin
            share_r <= alu_rsp.result[30:0];
            if (n_in) begin
              state <= ST_SHWR;
            end else begin
              loss  <= loss_sat;
              state <= ST_SHN;
            end
          end
        end
        ST_SHWR: state <= ST_SHN;
        ST_SHN: begin
          d     <= d + 2'd1;
          state <= (d == 2'd3) ? ST_NXC : ST_SHR;
        end
        ST_NXC: begin
          if (last_col && last_row) begin
            i     <= '0;
            state <= ST_QRD;
          end else begin
            i <= i + 1'b1;
            if (last_col) begin
              c <= '0;
              r <= r + 1'b1;
            end else begin
              c <= c + 1'b1;
            end
            state <= ST_CRD;
          end
        end
        ST_QRD: begin
          maddr <= i;
          state <= ST_QWT;
        end
        ST_QWT: state <= ST_QGET;
        ST_QGET: begin
          best <= best_c;
          if (last_cell) begin
            last_max <= best_c;
            state    <= ST_DONE;
          end else begin
            i     <= i + 1'b1;
            state <= ST_QRD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign ready              = state == ST_IDLE;
  assign res.valid          = state == ST_DONE;
  assign res.cell_water     = rd_val;
  assign res.max_half_spill = last_max;
  assign res.total_loss     = loss;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE) else $error("request taken while busy");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    res_take |-> res.valid) else $error("result taken before done");
  a_alu_free: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_rsp.busy) else $error("alu started while busy");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_take) |=> res.valid) else $error("result dropped");

endmodule

// ===== hdl/grid_water_spillage_step_unit.sv =====
// Write, add and read pass through the states OPWT, OPGET and DONE to the output register.
// A spillage minute skips each dry cell, weighs each wet cell against its neighbours and may
// spread its spill to the downhill ones (shared bit-serial multiply and divide), then updates every cell.
// One request at a time; the next is taken once the result sits in the output register.
// Reset: synchronous; a clearing pass over all 65536 addresses zeros the scratch stores,
// with no request taken meanwhile. Configuration writes are taken at any time.
module grid_water_spillage_step_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,  // cell_index, ground_height, water_amount, zero pad
  input  logic [1:0]   s_tuser,  // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // cell_water, max_half_spill, total_loss, below_threshold, pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [29:0]  cfg_data
);
  import gws_pkg::*;

  logic [SIZE_W-1:0] rows_reg;
  logic [SIZE_W-1:0] cols_reg;
  logic [29:0]       threshold;
  grid_cfg_t         cfg;
  cmd_t              cmd;
  res_t              res;
  logic              ready;
  logic              res_take;
  logic [SIZE_W-1:0] rows_c;
  logic [SIZE_W-1:0] cols_c;
  logic [17:0]       cells_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg  <= 9'd256;
      cols_reg  <= 9'd256;
      threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS:      rows_reg  <= cfg_data[SIZE_W-1:0];
        CFG_COLUMNS:   cols_reg  <= cfg_data[SIZE_W-1:0];
        CFG_THRESHOLD: threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the grid size to 1..max
  always_comb begin
    rows_c = (rows_reg == '0) ? 9'd1 :
             (rows_reg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_reg;
    cols_c = (cols_reg == '0) ? 9'd1 :
             (cols_reg > SIZE_W'(MAX_COLUMNS)) ? SIZE_W'(MAX_COLUMNS) : cols_reg;
    cells_full = rows_c * cols_c;
    cfg.rows   = rows_c;
    cfg.cols   = cols_c;
    cfg.cells  = cells_full[CNT_W-1:0];
  end

  assign cmd.mode          = s_tuser;
  assign cmd.cell_index    = s_tdata[15:0];
  assign cmd.ground_height = s_tdata[46:16];
  assign cmd.water_amount  = s_tdata[76:47];
  assign s_tready          = ready;

  gws_seq u_seq (
    .clk(clk), .rst(rst), .cfg(cfg), .start(s_tvalid & ready), .cmd(cmd),
    .ready(ready), .res(res), .res_take(res_take)
  );

  assign res_take = res.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {3'b0, res.max_half_spill <= threshold, res.total_loss,
                  res.max_half_spill, res.cell_water};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("output changed");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !res.valid) else $error("request taken with result due");
  a_take_slot: assert property (@(posedge clk) disable iff (rst)
    res_take |-> (!m_tvalid || m_tready)) else $error("output overwritten");

endmodule
